FILE: sv/pacs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pacs_pkg;

	// field and state widths
	localparam int HZ_W      = 40;
	localparam int FREQ_W    = 24;
	localparam int SAMPLE_W  = 24;
	localparam int PHASE_W   = 32;
	localparam int MUL_W     = 31;
	localparam int PROD_W    = 2 * MUL_W;

	// reset values
	localparam logic [HZ_W-1:0]    HZ_RESET    = 40'd5864062014;
	localparam logic [PHASE_W-1:0] PHASE_RESET = 32'hC000_0000;

	// default output fraction bits
	localparam int OUT_FRAC_BITS_DEF = 22;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MLO,
		ST_MHI,
		ST_STEP,
		ST_ADV,
		ST_FOLD,
		ST_SQR,
		ST_CUBE,
		ST_FIN
	} pacs_state_t;

	// shared multiplier operand select
	typedef enum logic [1:0] {
		MUL_FLO,
		MUL_FHI,
		MUL_SQR,
		MUL_CUBE
	} mul_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     save_lo;
		logic     step_en;
		logic     adv_en;
		logic     fold_en;
		logic     out_en;
	} pacs_cmd_t;

endpackage

`default_nettype wire

FILE: sv/phase_accumulator_cubic_sine.sv
// An accepted input word passes states MLO, MHI, STEP, ADV, FOLD, SQR, CUBE and
// FIN before its output word is valid. One item at a time, paced by the single
//   shared 31x31 multiplier used four times per item plus step, phase and fold.
// The next input word is taken while the previous output word waits.
// Reset (arst_n low): hz_to_step = 5864062014, phase = 0xC0000000, no word held.
`timescale 1ns / 1ps
`default_nettype none

module phase_accumulator_cubic_sine #(
	parameter int OUT_FRAC_BITS = pacs_pkg::OUT_FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 hz_to_step_we,
	input  wire logic        [pacs_pkg::HZ_W-1:0]     hz_to_step_wdata,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [pacs_pkg::FREQ_W-1:0]   frequency,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed      [pacs_pkg::SAMPLE_W-1:0] sample
);
	import pacs_pkg::*;

	pacs_cmd_t cmd;

	// sequencer
	pacs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// phase accumulator and cubic shaper
	pacs_dp #(
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.hz_to_step_we    (hz_to_step_we),
		.hz_to_step_wdata (hz_to_step_wdata),
		.frequency        (frequency),
		.sample           (sample)
	);

endmodule

`default_nettype wire

FILE: sv/pacs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pacs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pacs_pkg::pacs_cmd_t    cmd
);
	import pacs_pkg::*;

	pacs_state_t state_q, state_d;
	logic        out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.mul_sel = MUL_FLO;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MLO;
				end
			end
			ST_MLO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FLO;
				state_d     = ST_MHI;
			end
			ST_MHI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_FHI;
				cmd.save_lo = 1'b1;
				state_d     = ST_STEP;
			end
			ST_STEP: begin
				cmd.step_en = 1'b1;
				state_d     = ST_ADV;
			end
			ST_ADV: begin
				cmd.adv_en = 1'b1;
				state_d    = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold_en = 1'b1;
				state_d     = ST_SQR;
			end
			ST_SQR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SQR;
				state_d     = ST_CUBE;
			end
			ST_CUBE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CUBE;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_en = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/pacs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pacs_dp #(
	parameter int OUT_FRAC_BITS = pacs_pkg::OUT_FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire pacs_pkg::pacs_cmd_t                   cmd,
	input  wire logic                                  hz_to_step_we,
	input  wire logic        [pacs_pkg::HZ_W-1:0]      hz_to_step_wdata,
	input  wire logic signed [pacs_pkg::FREQ_W-1:0]    frequency,
	output logic signed      [pacs_pkg::SAMPLE_W-1:0]  sample
);
	import pacs_pkg::*;

	localparam int            HALF_W  = HZ_W / 2;
	localparam int            LO_W    = FREQ_W + HALF_W;
	localparam int            STEP_SH = 24;
	localparam int            SUM_W   = PHASE_W + STEP_SH;
	localparam int            M_W     = 34;
	localparam int            RSH     = 31 - OUT_FRAC_BITS;
	localparam logic [M_W-1:0] RND   = M_W'(1) << (30 - OUT_FRAC_BITS);
	localparam logic signed [M_W:0] YMAX = (M_W+1)'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [M_W:0] YMIN = -(M_W+1)'(2 ** (SAMPLE_W - 1));

	logic [HZ_W-1:0]    hz_q;
	logic [PHASE_W-1:0] phase_q;
	logic [FREQ_W-1:0]  mag_q;
	logic               neg_q;
	logic [LO_W-1:0]    lo_q;
	logic [PHASE_W-1:0] step_q;
	logic [MUL_W-1:0]   a_q;
	logic               uneg_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SAMPLE_W-1:0] sample_q;

	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [SUM_W-1:0]   sum;
	logic signed [M_W-1:0] p_ext, u;
	logic [M_W-1:0]     u_abs;
	logic [M_W-1:0]     m, r;
	logic signed [M_W:0] y;
	logic [SAMPLE_W-1:0] y_sat;

	// configuration register and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hz_q    <= HZ_RESET;
			phase_q <= PHASE_RESET;
		end else begin
			if (hz_to_step_we) begin
				hz_q <= hz_to_step_wdata;
			end
			if (cmd.adv_en) begin
				phase_q <= neg_q ? phase_q - step_q : phase_q + step_q;
			end
		end
	end

	// shared multiplier operand select
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_FLO: begin
				mul_a = MUL_W'(mag_q);
				mul_b = MUL_W'(hz_q[HALF_W-1:0]);
			end
			MUL_FHI: begin
				mul_a = MUL_W'(mag_q);
				mul_b = MUL_W'(hz_q[HZ_W-1:HALF_W]);
			end
			MUL_SQR: begin
				mul_a = a_q;
				mul_b = a_q;
			end
			MUL_CUBE: begin
				mul_a = a_q;
				mul_b = prod_q[60:30];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// step: high partial shifted over low partial, keep bits 55:24
	assign sum = {prod_q[SUM_W-HALF_W-1:0], {HALF_W{1'b0}}} + SUM_W'(lo_q);

	// fold phase into triangle, then magnitude
	assign p_ext = M_W'(signed'(phase_q));
	assign u     = (p_ext <= 0) ? (M_W'(1) << 30) + p_ext : (M_W'(1) << 30) - p_ext;
	assign u_abs = u[M_W-1] ? M_W'(-u) : M_W'(u);

	// 3a - a^3, rounded half up, sign applied, saturated
	assign m = (M_W'(a_q) << 1) + M_W'(a_q) - M_W'(prod_q[61:30]);
	assign r = (m + RND) >> RSH;
	assign y = uneg_q ? -signed'({1'b0, r}) : signed'({1'b0, r});

	always_comb begin
		if (y > YMAX) begin
			y_sat = YMAX[SAMPLE_W-1:0];
		end else if (y < YMIN) begin
			y_sat = YMIN[SAMPLE_W-1:0];
		end else begin
			y_sat = y[SAMPLE_W-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= frequency[FREQ_W-1];
			mag_q <= frequency[FREQ_W-1] ? FREQ_W'(-frequency) : FREQ_W'(frequency);
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (cmd.save_lo) begin
			lo_q <= prod_q[LO_W-1:0];
		end
		if (cmd.step_en) begin
			step_q <= sum[SUM_W-1:SUM_W-PHASE_W];
		end
		if (cmd.fold_en) begin
			a_q    <= u_abs[MUL_W-1:0];
			uneg_q <= u[M_W-1];
		end
		if (cmd.out_en) begin
			sample_q <= y_sat;
		end
	end

	assign sample = signed'(sample_q);

endmodule

`default_nettype wire

FILE: test/phase_accumulator_cubic_sine_tb.sv
`timescale 1ns / 1ps

module phase_accumulator_cubic_sine_tb;

	localparam int OUT_F = pacs_pkg::OUT_FRAC_BITS_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 15;
	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam longint SAMPLE_MAX = 8388607;
	localparam longint SAMPLE_MIN = -8388608;
	localparam logic [pacs_pkg::HZ_W-1:0] HZ_MAX = '1;

	typedef struct {
		logic signed [pacs_pkg::FREQ_W-1:0]   freq;
		logic signed [pacs_pkg::SAMPLE_W-1:0] value;
	} sample_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hz_to_step_we = 1'b0;
	logic [pacs_pkg::HZ_W-1:0] hz_to_step_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [pacs_pkg::FREQ_W-1:0] frequency = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [pacs_pkg::SAMPLE_W-1:0] sample;

	// oscillator model state
	logic [pacs_pkg::PHASE_W-1:0] osc_phase = pacs_pkg::PHASE_RESET;
	logic [pacs_pkg::HZ_W-1:0]    osc_hz = pacs_pkg::HZ_RESET;

	logic signed [pacs_pkg::FREQ_W-1:0] freq_pending[$];
	sample_exp_t samples_due[$];

	int errors = 0;
	int quiet = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_req = 0;
	int hold_ack = 0;
	bit idle_on = 1'b1;
	bit stall_on = 1'b1;

	phase_accumulator_cubic_sine #(
		.OUT_FRAC_BITS(OUT_F)
	) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.hz_to_step_we    (hz_to_step_we),
		.hz_to_step_wdata (hz_to_step_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.frequency        (frequency),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sample           (sample)
	);

	always #5 clk = ~clk;

	// advance the phase by one frequency word and shape it into a sample
	function automatic logic signed [pacs_pkg::SAMPLE_W-1:0] advance_oscillator(
		input logic signed [pacs_pkg::FREQ_W-1:0] freq
	);
		longint f;
		longint p;
		longint u;
		longint y;
		logic [63:0] mag;
		logic [63:0] prod;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] a3;
		logic [63:0] m;
		logic [63:0] r;
		logic [31:0] step;
		logic neg;
		f = freq;
		mag = (f < 0) ? -f : f;
		prod = mag * {24'd0, osc_hz};
		// magnitude truncated first, then the sign applied
		step = prod[55:24];
		if (f < 0)
			step = -step;
		osc_phase = osc_phase + step;
		// fold into triangle u in Q2.30
		p = $signed(osc_phase);
		u = (p <= 0) ? ONE_Q30 + p : ONE_Q30 - p;
		neg = (u < 0);
		a = neg ? -u : u;
		a2 = (a * a) >> 30;
		a3 = (a * a2) >> 30;
		m = 3 * a - a3;
		r = (m + (64'd1 << (30 - OUT_F))) >> (31 - OUT_F);
		y = neg ? -longint'(r) : longint'(r);
		if (y > SAMPLE_MAX)
			y = SAMPLE_MAX;
		if (y < SAMPLE_MIN)
			y = SAMPLE_MIN;
		return y[pacs_pkg::SAMPLE_W-1:0];
	endfunction

	// mix of full-range, audio-range and tiny frequencies
	function automatic logic signed [pacs_pkg::FREQ_W-1:0] pick_frequency();
		logic signed [pacs_pkg::FREQ_W-1:0] f;
		case ($urandom_range(0, 3))
			0, 1: f = $urandom;
			2: f = $urandom_range(0, 20000 * 256);
			default: f = $urandom_range(0, 255);
		endcase
		if ($urandom_range(0, 1) == 1)
			f = -f;
		return f;
	endfunction

	// driver: one word per handshake, random gaps after a word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			frequency <= '0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (freq_pending.size() > 0) begin
				in_valid <= 1'b1;
				frequency <= freq_pending.pop_front();
				if (idle_on && $urandom_range(0, 4) == 0)
					gap_left <= $urandom_range(1, 19);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall bursts, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (stall_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: predict on accepted input words, check accepted output words
	always @(posedge clk) begin
		sample_exp_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (samples_due.size() == 0) begin
					$display("%0t: unexpected sample word, expected none, got %0d", $time, sample);
					errors++;
				end else begin
					due = samples_due.pop_front();
					if (sample !== due.value) begin
						$display("%0t: sample mismatch (frequency %0d): expected %0d, got %0d",
							$time, due.freq, due.value, sample);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				due.freq = frequency;
				due.value = advance_oscillator(frequency);
				samples_due.push_back(due);
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("phase_accumulator_cubic_sine_tb failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	task automatic wait_drained();
		while (freq_pending.size() != 0 || in_valid || samples_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_hz_to_step(input logic [pacs_pkg::HZ_W-1:0] value);
		@(posedge clk);
		hz_to_step_we <= 1'b1;
		hz_to_step_wdata <= value;
		@(posedge clk);
		hz_to_step_we <= 1'b0;
		osc_hz = value;
	endtask

	task automatic queue_random(input int count);
		@(negedge clk);
		repeat (count) freq_pending.push_back(pick_frequency());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset factor: zero step first, then the field extremes, +1, -1 and 440 * 256
		@(negedge clk);
		freq_pending.push_back(0);
		freq_pending.push_back(24'sh7FFFFF);
		freq_pending.push_back(-24'sh800000);
		freq_pending.push_back(1);
		freq_pending.push_back(-1);
		freq_pending.push_back(440 * 256);
		wait_drained();

		// factor 2^32 makes step = frequency * 256: quarter-turn steps walk
		// through peak, zero crossing and trough exactly
		write_hz_to_step(40'h01_0000_0000);
		@(negedge clk);
		repeat (4) freq_pending.push_back(24'sh400000);
		repeat (4) freq_pending.push_back(-24'sh400000);
		freq_pending.push_back(24'sh400001);
		freq_pending.push_back(-24'sh400001);
		freq_pending.push_back(24'sh555555);
		freq_pending.push_back(24'shAAAAAA);
		freq_pending.push_back(24'sh7FFFFF);
		freq_pending.push_back(-24'sh800000);
		freq_pending.push_back(24'sh200000);
		freq_pending.push_back(-24'sh200000);
		wait_drained();

		// back to the 48 kHz factor
		write_hz_to_step(pacs_pkg::HZ_RESET);
		queue_random(600);
		wait_drained();

		// zero factor: phase frozen
		write_hz_to_step('0);
		queue_random(60);
		wait_drained();

		// largest factor, steps wrap; long receiver hold-off in the middle
		write_hz_to_step(HZ_MAX);
		queue_random(350);
		while (freq_pending.size() > 200)
			@(posedge clk);
		@(negedge clk);
		hold_req++;
		wait_drained();

		// random full-width factor
		write_hz_to_step({$urandom, $urandom} & HZ_MAX);
		queue_random(450);
		wait_drained();

		// a random typical sample rate, no idling on either side
		write_hz_to_step(pacs_pkg::HZ_W'(64'd281474976710656 / $urandom_range(8000, 192000)));
		@(negedge clk);
		idle_on = 1'b0;
		stall_on = 1'b0;
		queue_random(470);
		wait_drained();

		if (errors == 0 && samples_due.size() == 0)
			$display("phase_accumulator_cubic_sine_tb passed");
		else
			$display("phase_accumulator_cubic_sine_tb failed");
		$finish;
	end

endmodule
